// ----- src/assert_macros.svh -----
// Assertion macros shared by the NMEA field splitter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define NMEAFS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("NMEA splitter assertion failed");

// expr must hold at every clock edge outside reset.
`define NMEAFS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("NMEA splitter assertion failed");

`endif

// ----- src/nmeafs_pkg.sv -----
// Package for the NMEA sentence field splitter: parse modes, event codes,
// character constants, sentence ID table and the result record type.
// No dependencies.
`default_nettype none

package nmeafs_pkg;

  localparam int MAX_FIELDS_DEF      = 15;
  localparam int MAX_FIELD_CHARS_DEF = 15;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ID,
    MODE_FIELD,
    MODE_SKIP
  } mode_t;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_CHAR  = 2'd1;
  localparam logic [1:0] EV_COMMA = 2'd2;
  localparam logic [1:0] EV_END   = 2'd3;

  localparam logic [1:0] FIX_UNKNOWN = 2'd0;
  localparam logic [1:0] FIX_VALID   = 2'd1;
  localparam logic [1:0] FIX_VOID    = 2'd2;

  localparam logic [2:0] TYPE_RMC = 3'd1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam int NUM_TYPES = 6;

  // Last four ID characters of each known sentence, in type order.
  localparam logic [31:0] KNOWN_IDS [NUM_TYPES] = '{
    32'h50474C4C, 32'h50524D43, 32'h50565447,
    32'h50474741, 32'h50475341, 32'h50475356
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [2:0] stype;
    logic [3:0] field;
    logic [3:0] pos;
    logic [7:0] value;
    logic [1:0] fix;
    logic       ovf;
  } res_t;

  // Returns {hit, type} for the last four ID characters.
  function automatic logic [3:0] id_lookup(input logic [31:0] id);
    logic [3:0] r;
    r = 4'd0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (KNOWN_IDS[t] == id) begin
        r = {1'b1, 3'(t)};
      end
    end
    return r;
  endfunction

  // Saturates a zero-extended counter value at 15.
  function automatic logic [3:0] sat15(input logic [7:0] v);
    return (v > 8'd15) ? 4'd15 : v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/nmea_sentence_field_splitter_core.sv -----
// Top level of the NMEA sentence field splitter: input register, parser
// instance and result register. Depends on nmeafs_pkg, nmeafs_step and
// assert_macros.svh.
//
//   Channel  Ports                         Direction  Carries
//   in       in_valid/in_ready/in_rx_byte  input      one received byte
//   out      out_valid/out_ready/out_*     output     zero or one record per byte
//
// A byte is registered on transfer and parsed once the output register is free or
// being read; its record, if any, is then registered and shown on the output.
// One byte per cycle is sustained unless the output stalls; state updates per byte.
// A stalled output holds its record while the input register still takes one byte.
// Synchronous active-low reset returns the parser to idle with fix status unknown.
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_field_splitter_core #(
  parameter int MaxFields     = nmeafs_pkg::MAX_FIELDS_DEF,
  parameter int MaxFieldChars = nmeafs_pkg::MAX_FIELD_CHARS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_kind,
  output logic [2:0]      out_sentence_type,
  output logic [3:0]      out_field_number,
  output logic [3:0]      out_char_position,
  output logic [7:0]      out_char_value,
  output logic [1:0]      out_fix_status,
  output logic            out_overflow_flag
);

  logic             inq_v_r;
  logic [7:0]       inq_byte_r;
  logic             out_v_r;
  nmeafs_pkg::res_t out_r;
  nmeafs_pkg::res_t res;
  logic             adv;

  assign adv      = inq_v_r && (!out_v_r || out_ready);
  assign in_ready = !inq_v_r || adv;

  nmeafs_step #(
    .MaxFields     (MaxFields),
    .MaxFieldChars (MaxFieldChars)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (adv),
    .rx_byte (inq_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        inq_v_r <= 1'b1;
      end else if (adv) begin
        inq_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= res.valid;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_rx_byte;
    end
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_v_r;
  assign out_event_kind    = out_r.kind;
  assign out_sentence_type = out_r.stype;
  assign out_field_number  = out_r.field;
  assign out_char_position = out_r.pos;
  assign out_char_value    = out_r.value;
  assign out_fix_status    = out_r.fix;
  assign out_overflow_flag = out_r.ovf;

  `NMEAFS_ASSERT_IMPL(a_stall_cause, clk, rst_n,
    !in_ready, inq_v_r && out_v_r && !out_ready)
  `NMEAFS_ASSERT_IMPL(a_out_record, clk, rst_n,
    out_v_r, out_r.valid)

endmodule

`default_nettype wire

// ----- src/nmeafs_step.sv -----
// Sentence parser state and per-byte update for the NMEA field splitter.
// Depends on nmeafs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nmeafs_step #(
  parameter int MaxFields     = nmeafs_pkg::MAX_FIELDS_DEF,
  parameter int MaxFieldChars = nmeafs_pkg::MAX_FIELD_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [7:0]        rx_byte,
  output nmeafs_pkg::res_t       res
);

  localparam int FW = $clog2(MaxFields + 1);
  localparam int CW = $clog2(MaxFieldChars + 1);

  nmeafs_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]    id_cnt_r, id_cnt_nxt;
  logic [23:0]   id_chars_r, id_chars_nxt;
  logic [2:0]    type_r, type_nxt;
  logic [FW-1:0] field_r, field_nxt;
  logic [CW-1:0] char_r, char_nxt;
  logic [1:0]    fix_r, fix_nxt;
  logic          ovf_r, ovf_nxt;

  logic          is_dollar;
  logic [3:0]    lookup;
  logic          field_full;
  logic          char_full;

  assign is_dollar  = (rx_byte == nmeafs_pkg::CH_DOLLAR);
  assign lookup     = nmeafs_pkg::id_lookup({id_chars_r, rx_byte});
  assign field_full = (field_r >= FW'(MaxFields));
  assign char_full  = (char_r >= CW'(MaxFieldChars));

  always_comb begin
    mode_nxt = mode_r;
    if (go) begin
      if (is_dollar) begin
        mode_nxt = nmeafs_pkg::MODE_ID;
      end else begin
        unique case (mode_r)
          nmeafs_pkg::MODE_IDLE: mode_nxt = nmeafs_pkg::MODE_IDLE;
          nmeafs_pkg::MODE_ID: begin
            if (id_cnt_r == 3'd0 && rx_byte != nmeafs_pkg::CH_G) begin
              mode_nxt = nmeafs_pkg::MODE_SKIP;
            end else if (id_cnt_r == 3'd4) begin
              mode_nxt = lookup[3] ? nmeafs_pkg::MODE_FIELD : nmeafs_pkg::MODE_SKIP;
            end
          end
          nmeafs_pkg::MODE_FIELD: begin
            if (rx_byte == nmeafs_pkg::CH_LF) begin
              mode_nxt = nmeafs_pkg::MODE_IDLE;
            end
          end
          nmeafs_pkg::MODE_SKIP: mode_nxt = nmeafs_pkg::MODE_SKIP;
          default: mode_nxt = nmeafs_pkg::MODE_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    id_cnt_nxt   = id_cnt_r;
    id_chars_nxt = id_chars_r;
    type_nxt     = type_r;
    field_nxt    = field_r;
    char_nxt     = char_r;
    fix_nxt      = fix_r;
    ovf_nxt      = ovf_r;
    res          = '0;
    res.field    = nmeafs_pkg::sat15(8'(field_r));
    res.pos      = nmeafs_pkg::sat15(8'(char_r));
    if (go) begin
      if (is_dollar) begin
        id_cnt_nxt   = 3'd0;
        id_chars_nxt = '0;
      end else begin
        unique case (mode_r)
          nmeafs_pkg::MODE_ID: begin
            if (id_cnt_r == 3'd0) begin
              if (rx_byte == nmeafs_pkg::CH_G) begin
                id_cnt_nxt = 3'd1;
              end
            end else begin
              id_chars_nxt = {id_chars_r[15:0], rx_byte};
              id_cnt_nxt   = id_cnt_r + 3'd1;
              if (id_cnt_r == 3'd4 && lookup[3]) begin
                type_nxt  = lookup[2:0];
                field_nxt = '0;
                char_nxt  = CW'(5);
                ovf_nxt   = 1'b0;
                res.valid = 1'b1;
                res.kind  = nmeafs_pkg::EV_START;
                res.field = 4'd0;
                res.pos   = 4'd0;
              end
            end
          end
          nmeafs_pkg::MODE_FIELD: begin
            if (rx_byte == nmeafs_pkg::CH_LF) begin
              res.valid = 1'b1;
              res.kind  = nmeafs_pkg::EV_END;
            end else if (rx_byte == nmeafs_pkg::CH_COMMA) begin
              if (field_full) begin
                ovf_nxt = 1'b1;
              end else begin
                if (field_r >= FW'(MaxFields - 1)) begin
                  ovf_nxt = 1'b1;
                end
                res.valid = 1'b1;
                res.kind  = nmeafs_pkg::EV_COMMA;
                field_nxt = field_r + FW'(1);
                char_nxt  = '0;
              end
            end else if (rx_byte != nmeafs_pkg::CH_CR) begin
              if (field_full || char_full) begin
                ovf_nxt = 1'b1;
              end else begin
                if (type_r == nmeafs_pkg::TYPE_RMC && field_r == FW'(2) &&
                    char_r == '0) begin
                  if (rx_byte == nmeafs_pkg::CH_A) begin
                    fix_nxt = nmeafs_pkg::FIX_VALID;
                  end else if (rx_byte == nmeafs_pkg::CH_V) begin
                    fix_nxt = nmeafs_pkg::FIX_VOID;
                  end
                end
                res.valid = 1'b1;
                res.kind  = nmeafs_pkg::EV_CHAR;
                res.value = rx_byte;
                char_nxt  = char_r + CW'(1);
              end
            end
          end
          nmeafs_pkg::MODE_IDLE, nmeafs_pkg::MODE_SKIP: ;
          default: ;
        endcase
      end
    end
    res.stype = type_nxt;
    res.fix   = fix_nxt;
    res.ovf   = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= nmeafs_pkg::MODE_IDLE;
      id_cnt_r   <= '0;
      id_chars_r <= '0;
      type_r     <= '0;
      field_r    <= '0;
      char_r     <= '0;
      fix_r      <= nmeafs_pkg::FIX_UNKNOWN;
      ovf_r      <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      id_cnt_r   <= id_cnt_nxt;
      id_chars_r <= id_chars_nxt;
      type_r     <= type_nxt;
      field_r    <= field_nxt;
      char_r     <= char_nxt;
      fix_r      <= fix_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  `NMEAFS_ASSERT_ALWAYS(a_field_bound, clk, rst_n, field_r <= FW'(MaxFields))
  `NMEAFS_ASSERT_ALWAYS(a_char_bound, clk, rst_n, char_r <= CW'(MaxFieldChars))
  `NMEAFS_ASSERT_IMPL(a_start_clean, clk, rst_n,
    res.valid && res.kind == nmeafs_pkg::EV_START, res.field == 4'd0 && !res.ovf)
  `NMEAFS_ASSERT_IMPL(a_field_mode, clk, rst_n,
    res.valid && res.kind != nmeafs_pkg::EV_START, mode_r == nmeafs_pkg::MODE_FIELD)

endmodule

`default_nettype wire

// ----- bench/nmea_split_checker.sv -----
// Checker for the NMEA sentence field splitter: watches both channels, predicts the
// record that each transferred byte causes and compares it with the output transfers.
// Depends on nmeafs_pkg for the parse modes, event codes and sentence ID table.
module nmea_split_checker #(
  parameter int MaxFields     = nmeafs_pkg::MAX_FIELDS_DEF,
  parameter int MaxFieldChars = nmeafs_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_event_kind,
  input  logic [2:0] out_sentence_type,
  input  logic [3:0] out_field_number,
  input  logic [3:0] out_char_position,
  input  logic [7:0] out_char_value,
  input  logic [1:0] out_fix_status,
  input  logic       out_overflow_flag,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] stype;
    logic [3:0] field;
    logic [3:0] pos;
    logic [7:0] value;
    logic [1:0] fix;
    logic       ovf;
  } split_rec_t;

  split_rec_t          expected_records[$];
  nmeafs_pkg::mode_t   pmode;
  int unsigned         id_cnt;
  logic [31:0]         id_word;
  logic [2:0]          cur_type;
  int unsigned         fld_cnt;
  int unsigned         chr_cnt;
  logic [1:0]          fix;
  logic                ovf;
  int                  fail_count = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [3:0] clamp_index(input int unsigned v);
    return (v > 15) ? 4'd15 : v[3:0];
  endfunction

  function automatic void push_record(input logic [1:0] kind, input logic [7:0] ch);
    split_rec_t r;
    r.kind  = kind;
    r.stype = cur_type;
    r.field = clamp_index(fld_cnt);
    r.pos   = clamp_index(chr_cnt);
    r.value = ch;
    r.fix   = fix;
    r.ovf   = ovf;
    expected_records.push_back(r);
  endfunction

  function automatic void clear_parser();
    pmode    = nmeafs_pkg::MODE_IDLE;
    id_cnt   = 0;
    id_word  = '0;
    cur_type = '0;
    fld_cnt  = 0;
    chr_cnt  = 0;
    fix      = nmeafs_pkg::FIX_UNKNOWN;
    ovf      = 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    bit hit;
    hit = 1'b0;
    if (b == nmeafs_pkg::CH_DOLLAR) begin
      pmode   = nmeafs_pkg::MODE_ID;
      id_cnt  = 0;
      id_word = '0;
      return;
    end
    case (pmode)
      nmeafs_pkg::MODE_ID: begin
        if (id_cnt == 0) begin
          if (b != nmeafs_pkg::CH_G) pmode = nmeafs_pkg::MODE_SKIP;
          else id_cnt = 1;
        end else begin
          id_word = {id_word[23:0], b};
          id_cnt++;
          if (id_cnt == 5) begin
            for (int t = 0; t < nmeafs_pkg::NUM_TYPES; t++) begin
              if (nmeafs_pkg::KNOWN_IDS[t] == id_word) begin
                cur_type = 3'(t);
                hit      = 1'b1;
              end
            end
            if (hit) begin
              fld_cnt = 0;
              chr_cnt = 0;
              ovf     = 1'b0;
              pmode   = nmeafs_pkg::MODE_FIELD;
              push_record(nmeafs_pkg::EV_START, 8'h00);
              chr_cnt = 5;
            end else begin
              pmode = nmeafs_pkg::MODE_SKIP;
            end
          end
        end
      end
      nmeafs_pkg::MODE_FIELD: begin
        if (b == nmeafs_pkg::CH_LF) begin
          push_record(nmeafs_pkg::EV_END, 8'h00);
          pmode = nmeafs_pkg::MODE_IDLE;
        end else if (b == nmeafs_pkg::CH_COMMA) begin
          if (fld_cnt >= MaxFields) begin
            ovf = 1'b1;
          end else begin
            if (fld_cnt + 1 >= MaxFields) ovf = 1'b1;
            push_record(nmeafs_pkg::EV_COMMA, 8'h00);
            fld_cnt++;
            chr_cnt = 0;
          end
        end else if (b != nmeafs_pkg::CH_CR) begin
          if (fld_cnt >= MaxFields || chr_cnt >= MaxFieldChars) begin
            ovf = 1'b1;
          end else begin
            if (cur_type == nmeafs_pkg::TYPE_RMC && fld_cnt == 2 && chr_cnt == 0) begin
              if (b == nmeafs_pkg::CH_A) fix = nmeafs_pkg::FIX_VALID;
              else if (b == nmeafs_pkg::CH_V) fix = nmeafs_pkg::FIX_VOID;
            end
            push_record(nmeafs_pkg::EV_CHAR, b);
            chr_cnt++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_record();
    split_rec_t got;
    split_rec_t want;
    got = '{out_event_kind, out_sentence_type, out_field_number, out_char_position,
            out_char_value, out_fix_status, out_overflow_flag};
    if (expected_records.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected record kind=%0d type=%0d field=%0d pos=%0d char=%02h",
                 $realtime, got.kind, got.stype, got.field, got.pos, got.value);
      return;
    end
    want = expected_records.pop_front();
    if (got != want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: record mismatch", $realtime);
        $display("  expected kind=%0d type=%0d field=%0d pos=%0d char=%02h fix=%0d ovf=%0d",
                 want.kind, want.stype, want.field, want.pos, want.value, want.fix, want.ovf);
        $display("  actual   kind=%0d type=%0d field=%0d pos=%0d char=%02h fix=%0d ovf=%0d",
                 got.kind, got.stype, got.field, got.pos, got.value, got.fix, got.ovf);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_records.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (out_valid && out_ready) check_record();
    end
    pending <= expected_records.size();
    errors  <= fail_count;
  end

endmodule

// ----- bench/tb_nmea_sentence_field_splitter_core.sv -----
// Testbench top for the NMEA sentence field splitter: drives directed and random byte
// streams with bursty input and a stalling receiver, and gives the verdict.
// Depends on nmeafs_pkg, nmea_sentence_field_splitter_core and nmea_split_checker.
module tb_nmea_sentence_field_splitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [2:0] out_sentence_type;
  logic [3:0] out_field_number;
  logic [3:0] out_char_position;
  logic [7:0] out_char_value;
  logic [1:0] out_fix_status;
  logic       out_overflow_flag;
  int         errors;
  int         pending;

  int         burst_left = 0;
  int         sent_bytes = 0;
  int         rx_cycle = 0;
  int         hold_left = 0;
  bit         draining = 1'b0;
  rx_style_t  rx_style = RX_ALWAYS;

  nmea_sentence_field_splitter_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_sentence_type (out_sentence_type),
    .out_field_number  (out_field_number),
    .out_char_position (out_char_position),
    .out_char_value    (out_char_value),
    .out_fix_status    (out_fix_status),
    .out_overflow_flag (out_overflow_flag)
  );

  nmea_split_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_sentence_type (out_sentence_type),
    .out_field_number  (out_field_number),
    .out_char_position (out_char_position),
    .out_char_value    (out_char_value),
    .out_fix_status    (out_fix_status),
    .out_overflow_flag (out_overflow_flag),
    .errors            (errors),
    .pending           (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (draining) begin
        out_ready <= 1'b1;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_cycle % 900 == 400) begin
        out_ready <= 1'b0;
        hold_left = 150;
      end else begin
        if (rx_cycle % 64 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
        case (rx_style)
          RX_ALWAYS:   out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (rx_cycle % 5 != 0);
          default:     out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == nmeafs_pkg::CH_DOLLAR || c == nmeafs_pkg::CH_COMMA) c = 8'h30;
    return c;
  endfunction

  function automatic logic [7:0] field_char(input int stype, input int fld, input int pos);
    int r;
    r = $urandom_range(0, 15);
    if (stype == nmeafs_pkg::TYPE_RMC && fld == 2 && pos == 0) begin
      if (r < 6) return nmeafs_pkg::CH_A;
      if (r < 12) return nmeafs_pkg::CH_V;
      return plain_char();
    end
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return nmeafs_pkg::CH_CR;
    return plain_char();
  endfunction

  task automatic send_sentence(input int stype);
    logic [31:0] id;
    int          nfields;
    int          nchars;
    int          r;
    id = nmeafs_pkg::KNOWN_IDS[stype];
    send_byte(nmeafs_pkg::CH_DOLLAR);
    send_byte(nmeafs_pkg::CH_G);
    for (int k = 3; k >= 0; k--) send_byte(id[8*k +: 8]);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(plain_char());
    end
    nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 6);
    for (int f = 1; f <= nfields; f++) begin
      send_byte(nmeafs_pkg::CH_COMMA);
      nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 6);
      for (int c = 0; c < nchars; c++) send_byte(field_char(stype, f, c));
    end
    r = $urandom_range(0, 9);
    if (r < 5) begin
      send_byte(nmeafs_pkg::CH_CR);
      send_byte(nmeafs_pkg::CH_LF);
    end else if (r < 9) begin
      send_byte(nmeafs_pkg::CH_LF);
    end
  endtask

  task automatic send_random_unit();
    int          pick;
    logic [31:0] id;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 14) begin
      send_byte(nmeafs_pkg::CH_DOLLAR);
      b = 8'($urandom_range(0, 255));
      if (b == nmeafs_pkg::CH_G) b = 8'h50;
      send_byte(b);
      repeat ($urandom_range(0, 8)) begin
        send_byte(($urandom_range(0, 3) == 0) ? nmeafs_pkg::CH_COMMA : plain_char());
      end
      send_byte(nmeafs_pkg::CH_LF);
    end else if (pick < 22) begin
      id = nmeafs_pkg::KNOWN_IDS[$urandom_range(0, nmeafs_pkg::NUM_TYPES - 1)];
      id[8*$urandom_range(0, 3) +: 8] = plain_char();
      send_byte(nmeafs_pkg::CH_DOLLAR);
      send_byte(nmeafs_pkg::CH_G);
      for (int k = 3; k >= 0; k--) send_byte(id[8*k +: 8]);
      send_text(",12,A\r\n");
    end else begin
      send_sentence($urandom_range(0, nmeafs_pkg::NUM_TYPES - 1));
    end
  endtask

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int drain_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GPRMC,1,A\r\n");
    send_text("$GPVTG,,\n");
    send_text("$GPRMC,,V,\n");
    send_text("$GPRMC,,X\n");
    send_text("$PGPGGA,1\n");
    send_text("$GPXYZ,2\n");
    send_text("$GPG$GPGSA,");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(nmeafs_pkg::CH_LF);
    send_text("$GPGSV");
    repeat (17) send_byte(nmeafs_pkg::CH_COMMA);
    send_text("Z\n");
    send_text("$GPGGA,");
    repeat (17) send_byte(8'h7E);
    send_byte(nmeafs_pkg::CH_LF);
    send_text("$GPGLLabcdefghijkl,\n");

    while (sent_bytes < 600) send_random_unit();

    in_valid <= 1'b0;
    draining = 1'b1;
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
